FILE: rtl/tlik_pkg.sv
// package for the two-link arm inverse kinematics block
// widths, calibration tables, cordic step angles and the data types between cells
// no dependencies
`default_nettype none
package tlik_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int TABLE_POINTS    = 4;
	localparam int DEG_ONE         = 65536;
	localparam int CORDIC_STEPS    = 16;
	localparam int CORDIC_PRESHIFT = 8;
	localparam int SQRT_STEPS      = 21;
	localparam int DIV_STEPS       = 8;
	localparam int PWM_MIN         = 50;
	localparam int PWM_MAX         = 250;
	localparam int BIAS_SHIFT      = 7;
	localparam int INTERP_BIAS     = 1 << (BIAS_SHIFT - 1);

	localparam int TWO_L    = 15 << COORD_FRAC_BITS;
	localparam int TWO_L_SQ = TWO_L * TWO_L;

	localparam int CFG_W   = 13;
	localparam int IDX_W   = 2;
	localparam int XW      = 14;
	localparam int ZW      = 15;
	localparam int R2W     = 29;
	localparam int SQW     = 26;
	localparam int REMSQW  = 24;
	localparam int RADW    = 2 * SQRT_STEPS;
	localparam int ROOTW   = SQRT_STEPS;
	localparam int REMW    = ROOTW + 3;
	localparam int CW      = 33;
	localparam int AW      = 26;
	localparam int ANGW    = 28;
	localparam int SEGW    = 23;
	localparam int DENW    = SEGW + 1;
	localparam int NUMW    = 31;
	localparam int QW      = DIV_STEPS;
	localparam int PWMW    = 8;

	localparam logic [CFG_W-1:0] RST_SHOULDER_HEIGHT = 13'd2432;
	localparam logic [CFG_W-1:0] RST_MIN_RADIUS      = 13'd1024;
	localparam logic [CFG_W-1:0] RST_MAX_RADIUS      = 13'd3840;

	localparam int LIFT_DEG   [TABLE_POINTS] = '{0, 50, 55, 90};
	localparam int LIFT_PULSE [TABLE_POINTS] = '{220, 200, 150, 130};
	localparam int REACH_DEG  [TABLE_POINTS] = '{25, 45, 80, 140};
	localparam int REACH_PULSE[TABLE_POINTS] = '{130, 150, 180, 230};

	typedef enum logic [IDX_W-1:0] {
		REG_SHOULDER_HEIGHT = 2'd0,
		REG_MIN_RADIUS      = 2'd1,
		REG_MAX_RADIUS      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [RADW-1:0]  rad;
		logic [REMW-1:0]  rem;
		logic [ROOTW-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] ang;
	} cordic_t;

	typedef struct packed {
		logic [NUMW-1:0] num;
		logic [DENW-1:0] den;
		logic [QW-1:0]   q;
	} div_t;

	typedef struct packed {
		logic                 reach;
		logic signed [XW-1:0] x;
		logic signed [ZW-1:0] z;
	} sb_t;

	typedef struct packed {
		logic reach;
		logic zero;
	} flag_t;

	typedef struct packed {
		logic              cst;
		logic [PWMW-1:0]   ycst;
		logic [PWMW-1:0]   ya;
		logic signed [7:0] dy;
		logic [SEGW-1:0]   diff;
		logic [SEGW-1:0]   d;
	} seg_t;

	typedef struct packed {
		logic            cst;
		logic [PWMW-1:0] ycst;
		logic [PWMW-1:0] ya;
	} side_t;

	function automatic logic signed [AW-1:0] step_angle(input int i);
		logic signed [AW-1:0] a;
		unique case (i)
			0:  a = AW'(2949120);
			1:  a = AW'(1740967);
			2:  a = AW'(919879);
			3:  a = AW'(466945);
			4:  a = AW'(234379);
			5:  a = AW'(117304);
			6:  a = AW'(58666);
			7:  a = AW'(29335);
			8:  a = AW'(14668);
			9:  a = AW'(7334);
			10: a = AW'(3667);
			11: a = AW'(1833);
			12: a = AW'(917);
			13: a = AW'(458);
			14: a = AW'(229);
			15: a = AW'(115);
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic cordic_t pre_rotate(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		cordic_t c;
		c.x   = x;
		c.y   = y;
		c.ang = '0;
		if (x < 0) begin
			if (y >= 0) begin
				c.ang = AW'(90 * DEG_ONE);
				c.x   = y;
				c.y   = -x;
			end else begin
				c.ang = AW'(-90 * DEG_ONE);
				c.x   = -y;
				c.y   = x;
			end
		end
		return c;
	endfunction

	function automatic int pt_deg(input logic lift, input int i);
		return lift ? LIFT_DEG[i] : REACH_DEG[i];
	endfunction

	function automatic int pt_pwm(input logic lift, input int i);
		return lift ? LIFT_PULSE[i] : REACH_PULSE[i];
	endfunction

	function automatic seg_t seg_select(input logic signed [ANGW-1:0] a, input logic lift);
		seg_t s;
		logic found;
		logic signed [ANGW-1:0] xa;
		logic signed [ANGW-1:0] xb;
		s      = '0;
		found  = 1'b0;
		s.cst  = 1'b1;
		s.ycst = PWMW'(pt_pwm(lift, TABLE_POINTS - 1));
		if (a <= ANGW'(pt_deg(lift, 0) * DEG_ONE)) begin
			s.ycst = PWMW'(pt_pwm(lift, 0));
		end else begin
			for (int i = 1; i < TABLE_POINTS; i++) begin
				xa = ANGW'(pt_deg(lift, i - 1) * DEG_ONE);
				xb = ANGW'(pt_deg(lift, i) * DEG_ONE);
				if (!found && a <= xb) begin
					found  = 1'b1;
					s.cst  = 1'b0;
					s.ya   = PWMW'(pt_pwm(lift, i - 1));
					s.dy   = 8'(pt_pwm(lift, i) - pt_pwm(lift, i - 1));
					s.diff = SEGW'(a - xa);
					s.d    = SEGW'(xb - xa);
				end
			end
		end
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tlik_if.sv
// handshake channels of the inverse kinematics block: target, servo result, config write
// no dependencies
`default_nettype none
interface tlik_target_if;
	logic              valid;
	logic              ready;
	logic signed [13:0] target_x;
	logic signed [13:0] target_h;
	modport source (output valid, target_x, target_h, input ready);
	modport sink (input valid, target_x, target_h, output ready);
endinterface

interface tlik_servo_if;
	logic       valid;
	logic       ready;
	logic       reachable;
	logic [7:0] reach_servo_pwm;
	logic [7:0] lift_servo_pwm;
	modport source (output valid, reachable, reach_servo_pwm, lift_servo_pwm, input ready);
	modport sink (input valid, reachable, reach_servo_pwm, lift_servo_pwm, output ready);
endinterface

interface tlik_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tlik_sqrt_cell.sv
// one digit of the restoring square root, two radicand bits per cell
// depends on tlik_pkg
`default_nettype none
module tlik_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  tlik_pkg::sqrt_t d_in,
	output tlik_pkg::sqrt_t d_out
);
	import tlik_pkg::*;

	logic [REMW-1:0] part;
	logic [REMW-1:0] trial;
	sqrt_t           nxt;

	always_comb begin
		part    = {d_in.rem[REMW-3:0], d_in.rad[RADW-1 -: 2]};
		trial   = {1'b0, d_in.root, 2'b01};
		nxt.rad = {d_in.rad[RADW-3:0], 2'b00};
		if (part >= trial) begin
			nxt.rem  = part - trial;
			nxt.root = {d_in.root[ROOTW-2:0], 1'b1};
		end else begin
			nxt.rem  = part;
			nxt.root = {d_in.root[ROOTW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tlik_cordic_cell.sv
// one vectoring step of the atan2 cordic
// depends on tlik_pkg
`default_nettype none
module tlik_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             en,
	input  tlik_pkg::cordic_t d_in,
	output tlik_pkg::cordic_t d_out
);
	import tlik_pkg::*;

	logic signed [CW-1:0] xi;
	logic signed [CW-1:0] yi;
	logic signed [AW-1:0] ai;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	cordic_t              nxt;

	always_comb begin
		xi = $signed(d_in.x);
		yi = $signed(d_in.y);
		ai = $signed(d_in.ang);
		xs = xi >>> STEP;
		ys = yi >>> STEP;
		if (yi > 0) begin
			nxt.x   = xi + ys;
			nxt.y   = yi - xs;
			nxt.ang = ai + step_angle(STEP);
		end else begin
			nxt.x   = xi - ys;
			nxt.y   = yi + xs;
			nxt.ang = ai - step_angle(STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tlik_div_cell.sv
// one quotient bit of the restoring divider used for table interpolation
// depends on tlik_pkg
`default_nettype none
module tlik_div_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  tlik_pkg::div_t d_in,
	output tlik_pkg::div_t d_out
);
	import tlik_pkg::*;

	logic [NUMW-1:0] den_sh;
	div_t            nxt;

	always_comb begin
		den_sh  = NUMW'(d_in.den) << STEP;
		nxt     = d_in;
		if (d_in.num >= den_sh) begin
			nxt.num = d_in.num - den_sh;
			nxt.q   = d_in.q | (QW'(1) << STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/two_link_arm_inverse_kinematics.sv
// Two-link arm inverse kinematics: a gripper target goes in, elbow and shoulder servo pulse
// values come out. One target is taken every clock cycle unless the result is stalled;
// each passes a row of cells, one per square root digit (21), one per cordic step (16)
// and one per quotient bit of the interpolation divider (8), plus the squaring, reach test,
// pre-rotation, angle, segment, divider load and output stages. The whole row advances
// together, so a stalled result holds the row and input ready falls with it.
// Config writes are taken at any time and should be made while no target is in flight.
// depends on tlik_pkg, tlik_if, tlik_sqrt_cell, tlik_cordic_cell, tlik_div_cell
`default_nettype none
module two_link_arm_inverse_kinematics (
	input  logic clk,
	input  logic arst_n,
	tlik_target_if.sink  target,
	tlik_servo_if.source servo,
	tlik_cfg_if.sink     cfg
);
	import tlik_pkg::*;

	localparam int LAST = SQRT_STEPS + CORDIC_STEPS + DIV_STEPS + 6;

	logic en;
	logic vld_q [0:LAST];

	logic [CFG_W-1:0] sh_q;
	logic [CFG_W-1:0] rmin_q;
	logic [CFG_W-1:0] rmax_q;
	logic [SQW-1:0]   rmin_sq_q;
	logic [SQW-1:0]   rmax_sq_q;

	logic signed [XW-1:0] x_s1;
	logic signed [ZW-1:0] z_s1;
	logic [R2W-1:0]       r2_s1;

	logic signed [ZW-1:0]   zc;
	logic signed [27:0]     xsq;
	logic signed [29:0]     zsq;
	logic [R2W-1:0]         r2c;
	logic [REMSQW-1:0]      remc;

	sqrt_t   sq_r_q [0:SQRT_STEPS];
	sqrt_t   sq_s_q [0:SQRT_STEPS];
	sb_t     sb_q   [0:SQRT_STEPS];
	cordic_t co_p_q [0:CORDIC_STEPS];
	cordic_t co_f_q [0:CORDIC_STEPS];
	flag_t   fl_q   [0:CORDIC_STEPS];

	logic                   reach_a_q;
	logic signed [ANGW-1:0] alpha_q;
	logic signed [ANGW-1:0] beta_q;
	logic signed [AW-1:0]   psi;
	logic signed [AW-1:0]   phi0;

	logic reach_l1_q;
	seg_t seg_r_q;
	seg_t seg_l_q;

	div_t  dv_r_q [0:DIV_STEPS];
	div_t  dv_l_q [0:DIV_STEPS];
	side_t sd_r_q [0:DIV_STEPS];
	side_t sd_l_q [0:DIV_STEPS];
	logic  rch_q  [0:DIV_STEPS];

	logic            out_reach_q;
	logic [PWMW-1:0] out_rpwm_q;
	logic [PWMW-1:0] out_lpwm_q;

	function automatic div_t div_load(input seg_t s);
		div_t        dv;
		logic signed [31:0] prod;
		logic [32:0] numc;
		prod   = $signed({1'b0, s.diff}) * s.dy;
		numc   = ({prod[31], prod} << 1) + ({10'b0, s.d} << BIAS_SHIFT) + {10'b0, s.d};
		dv.num = NUMW'(numc);
		dv.den = {s.d, 1'b0};
		dv.q   = '0;
		return dv;
	endfunction

	function automatic logic [PWMW-1:0] finish(input side_t sd, input logic [QW-1:0] q);
		logic signed [9:0] v;
		if (sd.cst) begin
			v = $signed({2'b00, sd.ycst});
		end else begin
			v = $signed({2'b00, sd.ya}) + $signed({2'b00, q}) - 10'(INTERP_BIAS);
		end
		if (v < 10'(PWM_MIN)) begin
			v = 10'(PWM_MIN);
		end
		if (v > 10'(PWM_MAX)) begin
			v = 10'(PWM_MAX);
		end
		return v[PWMW-1:0];
	endfunction

	assign en           = !vld_q[LAST] || servo.ready;
	assign target.ready = en;
	assign cfg.ready    = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q      <= RST_SHOULDER_HEIGHT;
			rmin_q    <= RST_MIN_RADIUS;
			rmax_q    <= RST_MAX_RADIUS;
			rmin_sq_q <= SQW'(RST_MIN_RADIUS * RST_MIN_RADIUS);
			rmax_sq_q <= SQW'(RST_MAX_RADIUS * RST_MAX_RADIUS);
		end else begin
			rmin_sq_q <= SQW'(rmin_q * rmin_q);
			rmax_sq_q <= SQW'(rmax_q * rmax_q);
			if (cfg.valid) begin
				case (reg_idx_t'(cfg.index))
					REG_SHOULDER_HEIGHT: sh_q   <= cfg.data;
					REG_MIN_RADIUS:      rmin_q <= cfg.data;
					REG_MAX_RADIUS:      rmax_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAST; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= target.valid;
			for (int i = 1; i <= LAST; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// squared distance from the shoulder
	always_comb begin
		zc  = $signed({target.target_h[13], target.target_h}) - $signed({2'b00, sh_q});
		xsq = target.target_x * target.target_x;
		zsq = zc * zc;
		r2c = R2W'(xsq) + R2W'(zsq);
	end

	always_comb begin
		if (r2_s1 >= R2W'(TWO_L_SQ)) begin
			remc = '0;
		end else begin
			remc = REMSQW'(R2W'(TWO_L_SQ) - r2_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= target.target_x;
			z_s1  <= zc;
			r2_s1 <= r2c;
			sb_q[0].reach <= (r2_s1 >= R2W'(rmin_sq_q)) && (r2_s1 <= R2W'(rmax_sq_q));
			sb_q[0].x     <= x_s1;
			sb_q[0].z     <= z_s1;
			sq_r_q[0]     <= '{rad: {r2_s1[SQW-1:0], 16'b0}, rem: '0, root: '0};
			sq_s_q[0]     <= '{rad: {2'b00, remc, 16'b0}, rem: '0, root: '0};
			for (int i = 1; i <= SQRT_STEPS; i++) begin
				sb_q[i] <= sb_q[i-1];
			end
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		tlik_sqrt_cell u_r (.clk(clk), .en(en), .d_in(sq_r_q[k]), .d_out(sq_r_q[k+1]));
		tlik_sqrt_cell u_s (.clk(clk), .en(en), .d_in(sq_s_q[k]), .d_out(sq_s_q[k+1]));
	end

	// cordic inputs with quadrant pre-rotation
	always_ff @(posedge clk) begin
		if (en) begin
			co_p_q[0] <= pre_rotate(CW'($signed(sb_q[SQRT_STEPS].x)) <<< CORDIC_PRESHIFT,
				CW'($signed(sb_q[SQRT_STEPS].z)) <<< CORDIC_PRESHIFT);
			co_f_q[0] <= pre_rotate($signed(CW'(sq_r_q[SQRT_STEPS].root)) <<< CORDIC_PRESHIFT,
				$signed(CW'(sq_s_q[SQRT_STEPS].root)) <<< CORDIC_PRESHIFT);
			fl_q[0].reach <= sb_q[SQRT_STEPS].reach;
			fl_q[0].zero  <= (sb_q[SQRT_STEPS].x == '0) && (sb_q[SQRT_STEPS].z == '0);
			for (int i = 1; i <= CORDIC_STEPS; i++) begin
				fl_q[i] <= fl_q[i-1];
			end
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		tlik_cordic_cell #(.STEP(k)) u_p (
			.clk(clk), .en(en), .d_in(co_p_q[k]), .d_out(co_p_q[k+1])
		);
		tlik_cordic_cell #(.STEP(k)) u_f (
			.clk(clk), .en(en), .d_in(co_f_q[k]), .d_out(co_f_q[k+1])
		);
	end

	// joint angles
	always_comb begin
		psi  = fl_q[CORDIC_STEPS].zero ? '0 : $signed(co_p_q[CORDIC_STEPS].ang);
		phi0 = $signed(co_f_q[CORDIC_STEPS].ang);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			reach_a_q  <= fl_q[CORDIC_STEPS].reach;
			alpha_q    <= ANGW'(psi) + ANGW'(phi0);
			beta_q     <= ANGW'(180 * DEG_ONE) - (ANGW'(phi0) <<< 1);
			reach_l1_q <= reach_a_q;
			seg_r_q    <= seg_select(beta_q, 1'b0);
			seg_l_q    <= seg_select(alpha_q, 1'b1);
			dv_r_q[0]  <= div_load(seg_r_q);
			dv_l_q[0]  <= div_load(seg_l_q);
			sd_r_q[0]  <= '{cst: seg_r_q.cst, ycst: seg_r_q.ycst, ya: seg_r_q.ya};
			sd_l_q[0]  <= '{cst: seg_l_q.cst, ycst: seg_l_q.ycst, ya: seg_l_q.ya};
			rch_q[0]   <= reach_l1_q;
			for (int i = 1; i <= DIV_STEPS; i++) begin
				sd_r_q[i] <= sd_r_q[i-1];
				sd_l_q[i] <= sd_l_q[i-1];
				rch_q[i]  <= rch_q[i-1];
			end
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		tlik_div_cell #(.STEP(DIV_STEPS - 1 - k)) u_r (
			.clk(clk), .en(en), .d_in(dv_r_q[k]), .d_out(dv_r_q[k+1])
		);
		tlik_div_cell #(.STEP(DIV_STEPS - 1 - k)) u_l (
			.clk(clk), .en(en), .d_in(dv_l_q[k]), .d_out(dv_l_q[k+1])
		);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_reach_q <= rch_q[DIV_STEPS];
			out_rpwm_q  <= rch_q[DIV_STEPS] ? finish(sd_r_q[DIV_STEPS], dv_r_q[DIV_STEPS].q) : '0;
			out_lpwm_q  <= rch_q[DIV_STEPS] ? finish(sd_l_q[DIV_STEPS], dv_l_q[DIV_STEPS].q) : '0;
		end
	end

	assign servo.valid           = vld_q[LAST];
	assign servo.reachable       = out_reach_q;
	assign servo.reach_servo_pwm = out_rpwm_q;
	assign servo.lift_servo_pwm  = out_lpwm_q;

`ifndef SYNTH
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid && !servo.reachable |-> servo.reach_servo_pwm == '0
			&& servo.lift_servo_pwm == '0)
		else $error("unreachable result with nonzero pulse value");

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid && servo.reachable |-> servo.reach_servo_pwm >= 8'(PWM_MIN)
			&& servo.reach_servo_pwm <= 8'(PWM_MAX) && servo.lift_servo_pwm >= 8'(PWM_MIN)
			&& servo.lift_servo_pwm <= 8'(PWM_MAX))
		else $error("pulse value outside servo range");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid && !servo.ready |-> !target.ready)
		else $error("target taken while result stalled");
`endif
endmodule
`default_nettype wire
